// ===== rtl/utf8dec_pkg.sv =====
// Package: shared types and constants for the UTF-8 to code unit decoder.
`default_nettype none
package utf8dec_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int PEND_W = 2;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hF7;
  localparam logic [BYTE_W-1:0] NUL_BYTE    = 8'h00;

  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  // One decoded result as it leaves the decode core.
  typedef struct packed {
    logic              vld;
    logic [UNIT_W-1:0] code_unit;
    logic              is_end;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/utf8dec_in_reg.sv =====
// Input register stage: holds one byte until the decode core takes it.
`default_nettype none
module utf8dec_in_reg
  import utf8dec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              take,      // core consumes the held byte
  output logic                   byte_vld,
  output logic [BYTE_W-1:0]      byte_q
);

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  assign in_tready = !vld_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_q   = byte_r;

endmodule
`default_nettype wire

// ===== rtl/utf8dec_core.sv =====
// Decode core: sequence state and per-byte decode into a code unit.
`default_nettype none
module utf8dec_core
  import utf8dec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [BYTE_W-1:0] byte_q,
  output res_t                   res
);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [UNIT_W-1:0] part_r, part_nxt;
  logic [UNIT_W-1:0] shifted;

  assign shifted = {part_r[UNIT_W-7:0], byte_q[5:0]};

  always_comb begin
    pend_nxt      = pend_r;
    part_nxt      = part_r;
    res.vld       = 1'b0;
    res.code_unit = '0;
    res.is_end    = 1'b0;
    if (byte_q == NUL_BYTE) begin
      // terminator drops any open sequence
      pend_nxt   = PEND_NONE;
      part_nxt   = '0;
      res.vld    = 1'b1;
      res.is_end = 1'b1;
    end else if (pend_r != PEND_NONE) begin
      part_nxt = shifted;
      pend_nxt = pend_r - PEND_ONE;
      if (pend_r == PEND_ONE) begin
        res.vld       = 1'b1;
        res.code_unit = shifted;
      end
    end else if (byte_q < ASCII_LIMIT) begin
      res.vld       = 1'b1;
      res.code_unit = {{(UNIT_W-BYTE_W){1'b0}}, byte_q};
    end else begin
      case (byte_q) inside
        [LEAD2_LO:LEAD2_HI]: begin
          part_nxt = {{(UNIT_W-5){1'b0}}, byte_q[4:0]};
          pend_nxt = PEND_ONE;
        end
        [LEAD3_LO:LEAD3_HI]: begin
          part_nxt = {{(UNIT_W-4){1'b0}}, byte_q[3:0]};
          pend_nxt = PEND_TWO;
        end
        [LEAD4_LO:LEAD4_HI]: begin
          part_nxt = {{(UNIT_W-3){1'b0}}, byte_q[2:0]};
          pend_nxt = PEND_THREE;
        end
        default: begin
          // invalid lead: skipped, state kept
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      part_r <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utf8dec_out_reg.sv =====
// Output register stage: holds one result until the sink takes it.
`default_nettype none
module utf8dec_out_reg
  import utf8dec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  res_t                   res,
  output logic                   out_free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [UNIT_W-1:0]      out_code_unit,
  output logic                   out_is_end
);

  logic              vld_r, vld_nxt;
  logic [UNIT_W-1:0] unit_r;
  logic              end_r;

  assign out_free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= res.code_unit;
      end_r  <= res.is_end;
    end
  end

  assign out_tvalid    = vld_r;
  assign out_code_unit = unit_r;
  assign out_is_end    = end_r;

endmodule
`default_nettype wire

// ===== rtl/utf8_to_code_unit_decoder.sv =====
// Top level: UTF-8 byte stream to 16-bit code unit stream decoder.
// One UTF-8 byte enters per item and the block accepts a byte every cycle
// while the result side keeps up. Each byte passes an input register, a
// single decode step against the open-sequence state (pending count and
// partial value), and an output register. A byte that yields a code unit
// raises out_tvalid when its result is loaded into the output register.
// ASCII bytes give a code unit at once;
// lead bytes C0-DF, E0-EF, F0-F7 open two-, three- and four-byte sequences
// whose continuation bytes contribute their low six bits unchecked, and the
// code unit comes out with the last byte (four-byte results keep the low
// 16 bits). Invalid lead bytes are dropped silently. A zero byte ends the
// string: it gives code unit 0 with out_tlast high and drops any open
// sequence. Throughput is one byte per cycle, set by the single decode
// step between the two registers; a stalled sink holds the output register
// and backs up into the input register.
`default_nettype none
module utf8_to_code_unit_decoder
  import utf8dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] code_unit
  output logic             out_tlast   // is_end
);

  logic              byte_vld;
  logic [BYTE_W-1:0] byte_q;
  logic              out_free;
  logic              take;
  res_t              res;

  // the held byte moves on whenever the output register can take a result
  assign take = byte_vld && out_free;

  utf8dec_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .take      (take),
    .byte_vld  (byte_vld),
    .byte_q    (byte_q)
  );

  utf8dec_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .byte_q (byte_q),
    .res    (res)
  );

  utf8dec_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (take && res.vld),
    .res           (res),
    .out_free      (out_free),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_code_unit (out_tdata),
    .out_is_end    (out_tlast)
  );

endmodule
`default_nettype wire

// ===== rtl/utf8dec_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
`default_nettype none
module utf8dec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the end mark only comes with a zero code unit
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 16'h0000)
    else $error("end mark with nonzero code unit");

  // reset empties the result side
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with both sides idle and the sink free, the input side is ready
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid && !out_tvalid ##1 !in_tvalid && !out_tvalid |-> in_tready)
    else $error("input not ready while idle");

endmodule

bind utf8_to_code_unit_decoder utf8dec_checker u_utf8dec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the UTF-8 to 16-bit code unit decoder: directed and random stream traffic, scoreboard check.
module tb;
  import utf8dec_pkg::*;

  // One expected code unit as the sink should see it.
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
  } unit_exp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;   // [7:0] in_byte
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [UNIT_W-1:0] out_tdata;       // [15:0] code_unit
  logic              out_tlast;       // is_end

  // Bytes waiting to be offered, and code units waiting to be seen.
  logic [BYTE_W-1:0] byte_q[$];
  unit_exp_t         units_exp[$];

  // Decoder state mirrored in the scoreboard.
  logic [PEND_W-1:0] seq_left = PEND_NONE;
  logic [UNIT_W-1:0] seq_acc = '0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_asks = 0;       // bumped by the stimulus to ask for a long sink stall
  int  hold_seen = 0;
  int  hold_left = 0;
  int  fail_cnt = 0;
  int  counted_items = 0;
  logic in_took = 1'b0;     // byte accepted at the last rising edge

  utf8_to_code_unit_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Scoreboard decode step: updates the mirrored state and queues at most one code unit.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    unit_exp_t e;
    e.unit = '0;
    e.last = 1'b0;
    if (b == NUL_BYTE) begin
      // terminator drops any open sequence
      seq_left = PEND_NONE;
      seq_acc = '0;
      e.last = 1'b1;
      units_exp.push_back(e);
    end else if (seq_left != PEND_NONE) begin
      // continuation taken unchecked, top bits fall off the 16-bit store
      seq_acc = {seq_acc[UNIT_W-7:0], b[5:0]};
      seq_left = seq_left - 1'b1;
      if (seq_left == PEND_NONE) begin
        e.unit = seq_acc;
        units_exp.push_back(e);
      end
    end else if (b < ASCII_LIMIT) begin
      e.unit = {8'h00, b};
      units_exp.push_back(e);
    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      seq_acc = {11'd0, b[4:0]};
      seq_left = PEND_ONE;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      seq_acc = {12'd0, b[3:0]};
      seq_left = PEND_TWO;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      seq_acc = {13'd0, b[2:0]};
      seq_left = PEND_THREE;
    end
    // anything else is a stray lead byte: no unit, no state change
  endtask

  task automatic note_fail(input string what, input unit_exp_t want);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch (%s) at %0t: exp unit=%h end=%b, got unit=%h end=%b",
               what, $time, want.unit, want.last, out_tdata, out_tlast);
  endtask

  // Input side: note acceptance and predict at the edge where it happens.
  always @(posedge clk) begin
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      decode_byte(in_tdata);
  end

  // Input driver: offers the next byte after a handshake, or idles at random.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= byte_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random backpressure, plus a long stall whenever one is asked for.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen  <= hold_asks;
      hold_left  <= 80;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output monitor: every accepted unit must match the oldest expectation.
  always @(posedge clk) begin
    unit_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (units_exp.size() == 0) begin
        want = '0;
        note_fail("unexpected item", want);
      end else begin
        want = units_exp.pop_front();
        if (out_tdata !== want.unit || out_tlast !== want.last)
          note_fail("field", want);
      end
    end
  end

  function automatic logic [BYTE_W-1:0] cont_byte();
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  // Lead byte for a sequence of len bytes; len 1 is plain ASCII, never zero.
  function automatic logic [BYTE_W-1:0] lead_byte(input int len);
    case (len)
      2:       return 8'($urandom_range(LEAD2_HI, LEAD2_LO));
      3:       return 8'($urandom_range(LEAD3_HI, LEAD3_LO));
      4:       return 8'($urandom_range(LEAD4_HI, LEAD4_LO));
      default: return 8'($urandom_range(8'h7F, 8'h01));
    endcase
  endfunction

  // Mostly well-formed text with random content, some terminators, noise
  // bytes and cut-off sequences mixed in.
  task automatic queue_random_text(input int n_items);
    int pushed;
    int pick;
    int len;
    int cut;
    pushed = 0;
    while (pushed < n_items) begin
      pick = $urandom_range(99);
      if (pick < 67) begin
        len = (pick < 30) ? 1 : (pick < 45) ? 2 : (pick < 57) ? 3 : 4;
        byte_q.push_back(lead_byte(len));
        for (int i = 1; i < len; i++) byte_q.push_back(cont_byte());
        pushed += len;
      end else if (pick < 75) begin
        byte_q.push_back(NUL_BYTE);
        pushed++;
      end else if (pick < 87) begin
        // noise: any byte value
        byte_q.push_back(8'($urandom_range(255)));
        pushed++;
      end else begin
        // sequence cut short, then a zero or an arbitrary byte taken as continuation
        len = $urandom_range(4, 2);
        cut = $urandom_range(len - 2, 0);
        byte_q.push_back(lead_byte(len));
        for (int i = 0; i < cut; i++) byte_q.push_back(cont_byte());
        byte_q.push_back($urandom_range(1) ? NUL_BYTE : 8'($urandom_range(255, 1)));
        pushed += cut + 2;
      end
    end
    counted_items += pushed;
  endtask

  // Sender pause: waits until nothing is left to send and every expected unit
  // is seen, then lets a trailing byte still in the pipe settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_tvalid || units_exp.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 61;

    // Directed: range ends, every sequence length at its smallest value and
    // the one- to three-byte ones also at their largest, stray leads, zero
    // inside a sequence, and continuations that are really ASCII or lead bytes.
    byte_q = '{8'h00, 8'h7F,
               8'hC0, 8'h80, 8'hDF, 8'hBF,
               8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
               8'hF0, 8'h80, 8'h80, 8'h80,
               8'hF7, 8'hFF, 8'hC5, 8'h41,
               8'h80, 8'hF8,
               8'hE2, 8'h00, 8'h01};

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait_drained();

    queue_random_text(300);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 11;
    queue_random_text(300);
    wait_drained();

    // No idling; a long sink stall lets the decoder fill and push back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_text(300);
    hold_asks++;
    wait_drained();

    repeat (8) @(posedge clk);
    while (units_exp.size() != 0) note_fail("missing item", units_exp.pop_front());
    if (fail_cnt == 0)
      $display("PASS utf8_to_code_unit_decoder");
    else
      $display("FAIL utf8_to_code_unit_decoder");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAIL utf8_to_code_unit_decoder");
    $finish;
  end

endmodule
